@@ rtl/core/setq_pkg.sv @@
package setq_pkg;

   localparam int CAPACITY_DEFAULT    = 32;
   localparam int HANDLE_BITS_DEFAULT = 16;
   localparam int MAX_RESULTS         = 32;
   localparam int RESULT_CNT_W        = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_ADJUST = 2'd1,
      OP_DELETE = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_EXPIRED   = 3'd3,
      STAT_NONE      = 3'd4,
      STAT_DUP       = 3'd5
   } status_type;

   // where the handle of a result comes from
   typedef enum logic [1:0] {
      HSRC_REQ  = 2'd0,
      HSRC_HEAD = 2'd1,
      HSRC_ZERO = 2'd2
   } hsrc_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] handle;
      logic [31:0] expire_time;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] out_handle;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       lookup;
      logic       remove;
      logic       insert;
      logic       pop;
      logic       rsp_load;
      status_type rsp_status;
      hsrc_type   rsp_hsrc;
      logic       rsp_last;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   found;
      logic   full;
      logic   pop_ok;
      logic   pop_more;
   } ctrl_status_type;

endpackage

@@ rtl/core/sorted_expiry_timer_queue.sv @@
// Steps: add does a lookup then an insert, delete a lookup then a remove, adjust a
// lookup, a remove and an insert; a rejected add/adjust/delete stops after the lookup,
// and a tick does a lookup and then pops, one pop each cycle. Each result is registered,
// and a new item is accepted only when the controller is back in idle (busy low).
// Results are one-cycle strobes; the receiver cannot stall. Reset clears the occupancy
// and the controller; slot contents are left as they are, with no clearing pass.
module sorted_expiry_timer_queue #(
   parameter int CAPACITY    = setq_pkg::CAPACITY_DEFAULT,
   parameter int HANDLE_BITS = setq_pkg::HANDLE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  setq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output setq_pkg::rsp_type rsp_data
);
   import setq_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   setq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   setq_datapath #(
      .CAPACITY    (CAPACITY),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ rtl/core/setq_ctrl.sv @@
module setq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  setq_pkg::ctrl_status_type status,
   output setq_pkg::ctrl_cmd_type    cmd
);
   import setq_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_REMOVE = 5'b00100,
      ST_INSERT = 5'b01000,
      ST_POP    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.lookup   = 1'b1;
            cmd.rsp_hsrc = HSRC_REQ;
            cmd.rsp_last = 1'b1;
            case (status.op)
               OP_ADD: begin
                  if (status.found) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STAT_DUP;
                     state_in       = ST_IDLE;
                  end else if (status.full) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STAT_FULL;
                     state_in       = ST_IDLE;
                  end else begin
                     state_in = ST_INSERT;
                  end
               end
               OP_ADJUST, OP_DELETE: begin
                  if (!status.found) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = STAT_NOT_FOUND;
                     state_in       = ST_IDLE;
                  end else begin
                     state_in = ST_REMOVE;
                  end
               end
               default: begin
                  state_in = ST_POP;
               end
            endcase
         end
         ST_REMOVE: begin
            cmd.remove = 1'b1;
            if (status.op == OP_ADJUST) begin
               state_in = ST_INSERT;
            end else begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STAT_OK;
               cmd.rsp_hsrc   = HSRC_REQ;
               cmd.rsp_last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_INSERT: begin
            cmd.insert     = 1'b1;
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = STAT_OK;
            cmd.rsp_hsrc   = HSRC_REQ;
            cmd.rsp_last   = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_POP: begin
            cmd.rsp_load = 1'b1;
            if (status.pop_ok) begin
               cmd.pop        = 1'b1;
               cmd.rsp_status = STAT_EXPIRED;
               cmd.rsp_hsrc   = HSRC_HEAD;
               cmd.rsp_last   = !status.pop_more;
               if (!status.pop_more) begin
                  state_in = ST_IDLE;
               end
            end else begin
               // only reached before the first pop: nothing has expired
               cmd.rsp_status = STAT_NONE;
               cmd.rsp_hsrc   = HSRC_ZERO;
               cmd.rsp_last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_CHECK))
      else $error("accepted transfer did not enter lookup");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !status.full)
      else $error("insert into a full store");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && cmd.rsp_last) |=> (state_ff == ST_IDLE))
      else $error("controller still busy after final result");
`endif

endmodule

@@ rtl/core/setq_datapath.sv @@
module setq_datapath #(
   parameter int CAPACITY    = setq_pkg::CAPACITY_DEFAULT,
   parameter int HANDLE_BITS = setq_pkg::HANDLE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  setq_pkg::req_type         req_data,
   input  setq_pkg::ctrl_cmd_type    cmd,
   output setq_pkg::ctrl_status_type status,
   output logic                      rsp_strobe,
   output setq_pkg::rsp_type         rsp_data
);
   import setq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [31:0]             expiry_ff [CAPACITY];
   logic [31:0]             expiry_in [CAPACITY];
   logic [HANDLE_BITS-1:0]  handle_ff [CAPACITY];
   logic [HANDLE_BITS-1:0]  handle_in [CAPACITY];
   logic [CNT_W-1:0]        count_ff, count_in;

   op_type                  op_ff, op_in;
   logic [HANDLE_BITS-1:0]  key_ff, key_in;
   logic [31:0]             expire_ff, expire_in;
   logic [31:0]             now_ff, now_in;
   logic [RESULT_CNT_W-1:0] n_ff, n_in;
   logic [CAPACITY-1:0]     match_ff, match_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [CAPACITY-1:0]     hit;
   logic [CAPACITY-1:0]     after_pos;
   logic [CAPACITY-1:0]     behind;

   // per-slot compares, all independent
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         hit[i]       = (CNT_W'(i) < count_ff) && (handle_ff[i] == key_ff);
         after_pos[i] = |(match_ff & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i)));
         behind[i]    = (CNT_W'(i) >= count_ff) || (expiry_ff[i] > expire_ff);
      end
   end

   always_comb begin
      status.op       = op_ff;
      status.found    = |hit;
      status.full     = (count_ff == CNT_W'(CAPACITY));
      status.pop_ok   = (count_ff != '0) && (expiry_ff[0] <= now_ff)
                        && (n_ff < RESULT_CNT_W'(MAX_RESULTS));
      status.pop_more = (count_ff >= CNT_W'(2)) && (expiry_ff[1] <= now_ff)
                        && (n_ff < RESULT_CNT_W'(MAX_RESULTS - 1));
   end

   always_comb begin
      expiry_in = expiry_ff;
      handle_in = handle_ff;
      count_in  = count_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      expire_in = expire_ff;
      now_in    = now_ff;
      n_in      = n_ff;
      match_in  = match_ff;

      if (cmd.capture) begin
         op_in     = req_data.op;
         key_in    = HANDLE_BITS'(req_data.handle);
         expire_in = req_data.expire_time;
         now_in    = req_data.now;
         n_in      = '0;
      end

      if (cmd.lookup) begin
         match_in = hit;
      end

      // close the gap: every slot at or after the match takes its upper neighbor
      if (cmd.remove) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (after_pos[i]) begin
               expiry_in[i] = expiry_ff[i + 1];
               handle_in[i] = handle_ff[i + 1];
            end
         end
         count_in = count_ff - 1'b1;
      end

      // open a gap at the first later slot and drop the new timer in
      if (cmd.insert) begin
         if (behind[0]) begin
            expiry_in[0] = expire_ff;
            handle_in[0] = key_ff;
         end
         for (int i = 1; i < CAPACITY; i++) begin
            if (behind[i]) begin
               if (behind[i - 1]) begin
                  expiry_in[i] = expiry_ff[i - 1];
                  handle_in[i] = handle_ff[i - 1];
               end else begin
                  expiry_in[i] = expire_ff;
                  handle_in[i] = key_ff;
               end
            end
         end
         count_in = count_ff + 1'b1;
      end

      if (cmd.pop) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            expiry_in[i] = expiry_ff[i + 1];
            handle_in[i] = handle_ff[i + 1];
         end
         count_in = count_ff - 1'b1;
         n_in     = n_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_strobe_in      = cmd.rsp_load;
      rsp_data_in.status = cmd.rsp_status;
      rsp_data_in.last   = cmd.rsp_last;
      case (cmd.rsp_hsrc)
         HSRC_REQ: begin
            rsp_data_in.out_handle = 16'(key_ff);
         end
         HSRC_HEAD: begin
            rsp_data_in.out_handle = 16'(handle_ff[0]);
         end
         default: begin
            rsp_data_in.out_handle = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      expiry_ff   <= expiry_in;
      handle_ff   <= handle_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      expire_ff   <= expire_in;
      now_ff      <= now_in;
      n_ff        <= n_in;
      match_ff    <= match_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("occupancy above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow occupancy by one");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.remove || cmd.pop) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("remove or pop did not shrink occupancy by one");
`endif

endmodule
